// ===== hw/rtl/sha256_byte_stream_hasher_defines.svh =====
// Assertion helpers for the checker file.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumWords = 8;
  localparam int unsigned LenW = 64;
  localparam int unsigned PadStart = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic load_byte;    // write byte into buffer at fill position
    logic add_len;      // add 8 to bit length
    logic pad_byte;     // write the padding value at fill position
    logic zero_byte;    // write zero at fill position
    logic len_byte;     // write the length byte at fill position
    logic start_comp;   // begin compressing the buffered block
    logic clear_fill;   // fill count back to zero
    logic reset_msg;    // chain value and length to initial values
    logic out_load;     // capture the digest word given by out_idx
    logic [2:0] out_idx;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic comp_busy;
    logic comp_done;
  } sha_sts_t;

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage

// ===== hw/rtl/sha_datapath.sv =====
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  input  logic [7:0]        byte_i,
  output sha_pkg::sha_sts_t sts_o,
  output logic [31:0]       word_o
);
  import sha_pkg::*;

  logic [5:0]  fill_q, fill_d;
  logic [LenW-1:0] len_q;
  word_t       h_q [NumWords];
  word_t       r_q [NumWords];
  word_t       w_q [16];
  logic [5:0]  rnd_q;
  logic        busy_q, done_q;
  logic [2:0]  lsel;
  logic [4:0]  bsel;
  logic [7:0]  wr_byte;
  logic        wr_en;
  word_t       s0, s1, ch, mj, t1, t2, w_new, w_cur;

  assign sts_o.fill = fill_q;
  assign sts_o.comp_busy = busy_q;
  assign sts_o.comp_done = done_q;

  assign lsel = fill_q[2:0];
  // Bit offset of the fill position inside its big-endian word.
  assign bsel = {~fill_q[1:0], 3'b000};

  always_comb begin
    wr_en = cmd_i.load_byte | cmd_i.pad_byte | cmd_i.zero_byte | cmd_i.len_byte;
    wr_byte = 8'h00;
    if (cmd_i.load_byte) begin
      wr_byte = byte_i;
    end else if (cmd_i.pad_byte) begin
      wr_byte = PadByte;
    end else if (cmd_i.len_byte) begin
      wr_byte = len_q[8*(7-lsel) +: 8];
    end
    fill_d = fill_q;
    if (cmd_i.clear_fill) begin
      fill_d = '0;
    end else if (wr_en) begin
      fill_d = fill_q + 6'd1;
    end
  end

  // Round logic: the schedule window holds the next 16 words, w_q[0] is current.
  always_comb begin
    w_cur = w_q[0];
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    ch = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    mj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t1 = r_q[7] + (rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25)) + ch
         + RoundK[rnd_q] + w_cur;
    t2 = (rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22)) + mj;
  end

  // The schedule window doubles as the message buffer: bytes are written into it
  // one per cycle while no compression runs.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_comp) begin
      for (int i = 0; i < NumWords; i++) begin
        r_q[i] <= h_q[i];
      end
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end else if (wr_en) begin
      w_q[fill_q[5:2]][bsel +: 8] <= wr_byte;
    end
    if (cmd_i.out_load) begin
      word_o <= h_q[cmd_i.out_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < NumWords; i++) begin
        h_q[i] <= InitHash[i];
      end
    end else begin
      fill_q <= fill_d;
      done_q <= 1'b0;
      if (cmd_i.reset_msg) begin
        len_q <= '0;
        for (int i = 0; i < NumWords; i++) begin
          h_q[i] <= InitHash[i];
        end
      end else if (cmd_i.add_len) begin
        len_q <= len_q + LenW'(8);
      end
      if (cmd_i.start_comp) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
      // Fold the working variables in the cycle after the last round.
      if (done_q) begin
        for (int i = 0; i < NumWords; i++) begin
          h_q[i] <= h_q[i] + r_q[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              byte_present_i,
  input  logic              final_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        word_index_o,
  output logic              last_word_o,
  output sha_pkg::sha_cmd_t cmd_o,
  input  sha_pkg::sha_sts_t sts_i
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StComp, StPad, StLen, StFold, StOut
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;
  logic       lenpass_q, lenpass_d;
  logic       padded_q, padded_d;
  logic [2:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  logic       acc;

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = ov_q;
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);
  assign acc = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    fin_d = fin_q;
    lenpass_d = lenpass_q;
    padded_d = padded_q;
    idx_d = idx_q;
    ov_d = ov_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          fin_d = final_item_i;
          lenpass_d = 1'b0;
          padded_d = 1'b0;
          if (byte_present_i) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.add_len = 1'b1;
            if (sts_i.fill == 6'(BlockBytes - 1)) begin
              cmd_o.clear_fill = 1'b1;
              state_d = StComp;
            end else if (final_item_i) begin
              state_d = StPad;
            end
          end else if (final_item_i) begin
            state_d = StPad;
          end
        end
      end
      StComp: begin
        // Start the rounds in the cycle after the last buffer write.
        if (!sts_i.comp_busy && !sts_i.comp_done) begin
          cmd_o.start_comp = 1'b1;
        end
        if (sts_i.comp_done) begin
          state_d = StFold;
        end
      end
      StFold: begin
        if (!fin_q) begin
          state_d = StIdle;
        end else if (lenpass_q) begin
          idx_d = '0;
          ov_d = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_idx = '0;
          state_d = StOut;
        end else if (padded_q) begin
          // The marker went into the previous block; this one holds zeros and the length.
          lenpass_d = 1'b1;
          state_d = StLen;
        end else begin
          state_d = StPad;
        end
      end
      StPad: begin
        cmd_o.pad_byte = 1'b1;
        padded_d = 1'b1;
        if (sts_i.fill == 6'(BlockBytes - 1)) begin
          cmd_o.clear_fill = 1'b1;
          state_d = StComp;
        end else begin
          // Once the fill reaches the length field, the padding spills into one more block.
          lenpass_d = (sts_i.fill < 6'(PadStart));
          state_d = StLen;
        end
      end
      StLen: begin
        if (!lenpass_q || sts_i.fill < 6'(PadStart)) begin
          cmd_o.zero_byte = 1'b1;
        end else begin
          cmd_o.len_byte = 1'b1;
        end
        if (sts_i.fill == 6'(BlockBytes - 1)) begin
          cmd_o.clear_fill = 1'b1;
          state_d = StComp;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          if (idx_q == 3'd7) begin
            ov_d = 1'b0;
            cmd_o.reset_msg = 1'b1;
            state_d = StIdle;
          end else begin
            idx_d = idx_q + 3'd1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_idx = idx_q + 3'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q <= 1'b0;
      lenpass_q <= 1'b0;
      padded_q <= 1'b0;
      idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q <= fin_d;
      lenpass_q <= lenpass_d;
      padded_q <= padded_d;
      idx_q <= idx_d;
      ov_q <= ov_d;
    end
  end

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// Byte in, digest out: a non-final byte that fills a block starts a compression before the
// next accept. A final item pads, compresses one or two blocks and yields 8 beats; each
// stall on the result side delays the next accept. The 64-round compression runs at one
// round per cycle. One item is handled at a time. Reset clears control state and restores
// the initial hash values; the message buffer is not cleared.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_present_i, .final_item_i,
    .out_valid_o, .out_ready_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(data_byte_i), .sts_o(sts),
    .word_o(digest_word_o)
  );

endmodule

// ===== hw/rtl/sha_checker.sv =====
`include "sha256_byte_stream_hasher_defines.svh"

module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  `SHA_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_o, last_word_o == (word_index_o == 3'd7), "last")
  `SHA_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready during digest")
  `SHA_ASSERT_NXT(a_step, clk_i, rst_ni, out_valid_o && out_ready_i && !last_word_o,
                  out_valid_o && word_index_o == $past(word_index_o) + 3'd1, "index")
  `SHA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(digest_word_o), "hold")
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (.*);

// ===== verif/sha256_byte_stream_hasher_tb.sv =====
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  typedef struct packed {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        final_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_byte_stream_hasher uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .byte_present_i,
    .final_item_i, .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o,
    .last_word_o
  );

  always #2 clk_i = ~clk_i;

  // Predicted hasher state.
  word_t        hash_state [NumWords];
  logic [7:0]   msg_block [BlockBytes];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;
  digest_beat_t pending_digests[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_enable = 1'b1;

  function automatic word_t ror32(word_t v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic clear_hash_state();
    for (int i = 0; i < NumWords; i++) hash_state[i] = InitHash[i];
    block_fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_msg_block();
    word_t w [64];
    word_t v [8];
    word_t t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      w[t] = w[t-16] + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic predict_digest(logic [7:0] b, logic present, logic fin);
    digest_beat_t beat;
    if (present) begin
      msg_block[block_fill] = b;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == BlockBytes) begin
        compress_msg_block();
        block_fill = 0;
      end
    end
    if (fin) begin
      msg_block[block_fill] = PadByte;
      block_fill++;
      if (block_fill > PadStart) begin
        while (block_fill < BlockBytes) msg_block[block_fill++] = 8'h00;
        compress_msg_block();
        block_fill = 0;
      end
      while (block_fill < PadStart) msg_block[block_fill++] = 8'h00;
      for (int k = 0; k < 8; k++) msg_block[PadStart + k] = msg_bits[8*(7-k) +: 8];
      compress_msg_block();
      for (int k = 0; k < NumWords; k++) begin
        beat.digest = hash_state[k];
        beat.index  = k[2:0];
        beat.last   = (k == NumWords - 1);
        pending_digests.push_back(beat);
      end
      clear_hash_state();
    end
  endtask

  // Valid drops only for an idle burst, so back-to-back beats keep it high.
  task automatic send_byte_item(logic [7:0] b, logic present, logic fin);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    byte_present_i <= present;
    final_item_i   <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_digest(b, present, fin);
    @(negedge clk_i);
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++) send_byte_item(8'($urandom), 1'b1, 1'b0);
    send_byte_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Result side: random stalls on ready, compare each beat to the oldest prediction.
  initial begin
    digest_beat_t want;
    forever begin
      @(negedge clk_i);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_digests.size() == 0) begin
          $display("%0t: unexpected beat digest=%h index=%0d", $time, digest_word_o,
                   word_index_o);
          error_count++;
        end else begin
          want = pending_digests.pop_front();
          if (digest_word_o !== want.digest || word_index_o !== want.index ||
              last_word_o !== want.last) begin
            $display("%0t: expected %h/%0d/%b, actual %h/%0d/%b", $time, want.digest,
                     want.index, want.last, digest_word_o, word_index_o, last_word_o);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 2_000_000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_empty_message();
    send_byte_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_extreme_bytes();
    send_byte_item(8'h00, 1'b1, 1'b0);
    send_byte_item(8'hff, 1'b1, 1'b0);
    send_byte_item(8'h00, 1'b0, 1'b0);
    send_byte_item(8'h5a, 1'b1, 1'b1);
  endtask

  task automatic test_idle_items();
    send_byte_item(8'hff, 1'b0, 1'b0);
    send_byte_item(8'ha5, 1'b1, 1'b0);
    send_byte_item(8'h3c, 1'b0, 1'b0);
    send_byte_item(8'h00, 1'b0, 1'b1);
  endtask

  // Padding boundaries: 120 bytes fill one block and spill the padding into the
  // length field; 64 bytes whose last one rides on the final item end exactly on a block.
  task automatic test_pad_boundaries();
    send_message(120);
    for (int i = 0; i < 63; i++) send_byte_item(8'($urandom), 1'b1, 1'b0);
    send_byte_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned len;
    for (int m = 0; m < 6; m++) begin
      if (m == 4) idle_enable = 1'b0;
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_byte_item(8'($urandom), 1'b0, 1'b0);
        send_byte_item(8'($urandom), 1'b1, 1'b0);
      end
      send_byte_item(8'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  initial begin
    clear_hash_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_message();
    test_extreme_bytes();
    test_idle_items();
    test_pad_boundaries();
    test_random_messages();
    in_valid_i <= 1'b0;
    wait (pending_digests.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && pending_digests.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
